// ===== design/dtp_pkg.sv =====
package dtp_pkg;

  // Width of the segment counters; segments never exceed 23 bytes.
  localparam int CNT_W = 5;

  // Segment tags on the result channel.
  localparam logic [1:0] TAG_USER    = 2'd0;
  localparam logic [1:0] TAG_DEVICE  = 2'd1;
  localparam logic [1:0] TAG_EXT     = 2'd2;
  localparam logic [1:0] TAG_SUMMARY = 2'd3;

  // Message kinds.
  localparam logic [3:0] KIND_UNKNOWN      = 4'd0;
  localparam logic [3:0] KIND_EXT_REQUEST  = 4'd9;
  localparam logic [3:0] KIND_EXT_RESPONSE = 4'd10;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_EXT_CAPTURE  = 1'b0;
  localparam logic REG_EXT_CAPACITY = 1'b1;

  localparam logic [7:0] SLASH = 8'h2F;

  // Length of the fixed topic head.
  localparam logic [2:0] HEAD_LEN = 3'd6;

  // Handoff from the parser to the emitter at the end of a topic.
  typedef struct packed {
    logic             ok;
    logic [3:0]       kind;
    logic [CNT_W-1:0] ucnt;
    logic [CNT_W-1:0] dcnt;
    logic [CNT_W-1:0] ecnt;
  } dtp_job_t;

  // Characters of the fixed topic head.
  function automatic logic [7:0] head_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h6D;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6E;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of the extension marker "ext/".
  function automatic logic [7:0] ext_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = "e";
      2'd1:    ch = "x";
      2'd2:    ch = "t";
      default: ch = "/";
    endcase
    return ch;
  endfunction

  // Characters of the verbs "req" (verb 0) and "res" (verb 1).
  function automatic logic [7:0] verb_char(input logic verb, input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = "r";
      2'd1:    ch = "e";
      2'd2:    ch = verb ? "s" : "q";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Lengths of the eight fixed suffixes.
  function automatic logic [4:0] flat_len(input logic [2:0] idx);
    logic [4:0] len;
    case (idx)
      3'd0:    len = 5'd9;
      3'd1:    len = 5'd5;
      3'd2:    len = 5'd9;
      3'd3:    len = 5'd16;
      3'd4:    len = 5'd11;
      3'd5:    len = 5'd7;
      3'd6:    len = 5'd13;
      default: len = 5'd12;
    endcase
    return len;
  endfunction

  // Text of the fixed suffixes, right-justified in 16 bytes.
  function automatic logic [127:0] flat_str(input logic [2:0] idx);
    logic [127:0] s;
    case (idx)
      3'd0:    s = "telemetry";
      3'd1:    s = "hello";
      3'd2:    s = "heartbeat";
      3'd3:    s = "register-request";
      3'd4:    s = "command/ack";
      3'd5:    s = "command";
      3'd6:    s = "twin/reported";
      default: s = "twin/desired";
    endcase
    return s;
  endfunction

  // Character pos of suffix idx; only meaningful when pos is below its length.
  function automatic logic [7:0] flat_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [127:0] s;
    logic [3:0]   k;
    s = flat_str(idx);
    k = 4'(flat_len(idx) - 5'd1 - {1'b0, pos});
    return s[{k, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/dtp_if.sv =====
// Topic character channel.
interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] topic_char;
  logic       end_of_topic;

  modport source (output valid, output topic_char, output end_of_topic, input ready);
  modport sink   (input valid, input topic_char, input end_of_topic, output ready);
endinterface

// Result item channel.
interface dtp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] segment_tag;
  logic [7:0] segment_byte;
  logic       parse_ok;
  logic [3:0] message_kind;
  logic [3:0] user_length;
  logic [4:0] device_length;
  logic [3:0] ext_length;
  logic       last_of_run;

  modport source (output valid, output segment_tag, output segment_byte, output parse_ok,
                  output message_kind, output user_length, output device_length,
                  output ext_length, output last_of_run, input ready);
  modport sink   (input valid, input segment_tag, input segment_byte, input parse_ok,
                  input message_kind, input user_length, input device_length,
                  input ext_length, input last_of_run, output ready);
endinterface

// ===== design/dtp_ram.sv =====
module dtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 56,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/dtp_parse.sv =====
module dtp_parse
  import dtp_pkg::*;
#(
  parameter int USER_MAX   = 16,
  parameter int DEVICE_MAX = 24,
  parameter int EXT_MAX    = 16,
  parameter int AW         = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    topic_char,
  input  logic          end_of_topic,
  input  logic          ext_capture,
  input  logic [4:0]    ext_capacity,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          start,
  output dtp_job_t      job
);

  typedef enum logic [5:0] {
    PH_PREFIX   = 6'b000001,
    PH_USER     = 6'b000010,
    PH_DEVICE   = 6'b000100,
    PH_REST     = 6'b001000,
    PH_EXT_TYPE = 6'b010000,
    PH_EXT_VERB = 6'b100000
  } phase_t;

  localparam logic [AW-1:0] DEVICE_BASE = AW'(USER_MAX);
  localparam logic [AW-1:0] EXT_BASE    = AW'(USER_MAX + DEVICE_MAX);

  phase_t           phase, phase_next;
  logic [2:0]       prefix_pos, prefix_pos_next;
  logic [CNT_W-1:0] user_count, user_count_next;
  logic [CNT_W-1:0] device_count, device_count_next;
  logic [CNT_W-1:0] ext_count, ext_count_next;
  logic [4:0]       rest_pos, rest_pos_next;
  logic [9:0]       cand, cand_next;
  logic             failed, failed_next;
  logic [4:0]       cap;
  logic [4:0]       rest_bump;
  logic [3:0]       kind;
  logic             is_slash;

  assign cap       = (ext_capacity > 5'(EXT_MAX)) ? 5'(EXT_MAX) : ext_capacity;
  assign rest_bump = (rest_pos == 5'd31) ? rest_pos : rest_pos + 5'd1;
  assign is_slash  = (topic_char == SLASH);
  assign wr_data   = topic_char;

  // Per-character parse step.
  always_comb begin
    phase_next        = phase;
    prefix_pos_next   = prefix_pos;
    user_count_next   = user_count;
    device_count_next = device_count;
    ext_count_next    = ext_count;
    rest_pos_next     = rest_pos;
    cand_next         = cand;
    failed_next       = failed;
    wr_en             = 1'b0;
    wr_addr           = AW'(user_count);
    if (!failed) begin
      case (phase)
        PH_PREFIX: begin
          if (prefix_pos < HEAD_LEN && topic_char == head_char(prefix_pos)) begin
            prefix_pos_next = prefix_pos + 3'd1;
            if (prefix_pos_next == HEAD_LEN) begin
              phase_next = PH_USER;
            end
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_USER: begin
          if (is_slash) begin
            phase_next = PH_DEVICE;
          end else if ({1'b0, user_count} + 6'd2 > 6'(USER_MAX)) begin
            failed_next = 1'b1;
          end else begin
            wr_en           = accept;
            wr_addr         = AW'(user_count);
            user_count_next = user_count + 5'd1;
          end
        end
        PH_DEVICE: begin
          if (is_slash) begin
            phase_next    = PH_REST;
            rest_pos_next = 5'd0;
            cand_next     = 10'h1FF;
          end else if ({1'b0, device_count} + 6'd2 > 6'(DEVICE_MAX)) begin
            failed_next = 1'b1;
          end else begin
            wr_en             = accept;
            wr_addr           = DEVICE_BASE + AW'(device_count);
            device_count_next = device_count + 5'd1;
          end
        end
        PH_REST: begin
          // Narrow the fixed-suffix and extension candidates in parallel.
          for (int i = 0; i < 8; i++) begin
            if (!(rest_pos < flat_len(3'(i)) &&
                  topic_char == flat_char(3'(i), rest_pos[3:0]))) begin
              cand_next[i] = 1'b0;
            end
          end
          if (!(rest_pos < 5'd4 && topic_char == ext_char(rest_pos[1:0]))) begin
            cand_next[8] = 1'b0;
          end
          rest_pos_next = rest_bump;
          if (cand_next[8] && rest_bump == 5'd4) begin
            phase_next     = PH_EXT_TYPE;
            ext_count_next = '0;
          end
        end
        PH_EXT_TYPE: begin
          if (is_slash) begin
            if (ext_capture && cap == 5'd0) begin
              failed_next = 1'b1;
            end else begin
              phase_next    = PH_EXT_VERB;
              rest_pos_next = 5'd0;
              cand_next     = 10'h300;
            end
          end else if (ext_capture) begin
            if ({1'b0, ext_count} + 6'd2 > {1'b0, cap}) begin
              failed_next = 1'b1;
            end else begin
              wr_en          = accept;
              wr_addr        = EXT_BASE + AW'(ext_count);
              ext_count_next = ext_count + 5'd1;
            end
          end
        end
        PH_EXT_VERB: begin
          for (int i = 0; i < 2; i++) begin
            if (!(rest_pos < 5'd3 && topic_char == verb_char(i[0], rest_pos[1:0]))) begin
              cand_next[8+i] = 1'b0;
            end
          end
          rest_pos_next = rest_bump;
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  // Classify the topic from the state after the final character.
  always_comb begin
    kind = KIND_UNKNOWN;
    if (!failed_next) begin
      if (phase_next == PH_REST) begin
        for (int i = 7; i >= 0; i--) begin
          if (cand_next[i] && rest_pos_next == flat_len(3'(i))) begin
            kind = 4'(i + 1);
          end
        end
      end else if (phase_next == PH_EXT_VERB && rest_pos_next == 5'd3) begin
        if (cand_next[8]) begin
          kind = KIND_EXT_REQUEST;
        end else if (cand_next[9]) begin
          kind = KIND_EXT_RESPONSE;
        end
      end
    end
  end

  // Summary handed to the emitter; all zero on a failed parse.
  always_comb begin
    start    = accept && end_of_topic;
    job      = '0;
    if (kind != KIND_UNKNOWN) begin
      job.ok   = 1'b1;
      job.kind = kind;
      job.ucnt = user_count_next;
      job.dcnt = device_count_next;
      job.ecnt = (kind >= KIND_EXT_REQUEST) ? ext_count_next : '0;
    end
  end

  // Parse state registers; the final character clears them for the next topic.
  always_ff @(posedge clk) begin
    if (rst || start) begin
      phase        <= PH_PREFIX;
      prefix_pos   <= '0;
      user_count   <= '0;
      device_count <= '0;
      ext_count    <= '0;
      rest_pos     <= '0;
      cand         <= 10'h3FF;
      failed       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      prefix_pos   <= prefix_pos_next;
      user_count   <= user_count_next;
      device_count <= device_count_next;
      ext_count    <= ext_count_next;
      rest_pos     <= rest_pos_next;
      cand         <= cand_next;
      failed       <= failed_next;
    end
  end

endmodule

// ===== design/dtp_emit.sv =====
module dtp_emit
  import dtp_pkg::*;
#(
  parameter int USER_MAX   = 16,
  parameter int DEVICE_MAX = 24,
  parameter int AW         = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dtp_job_t      job_in,
  output logic          idle,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  dtp_out_if.source     result
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_NEXT = 4'b0010,
    E_LOAD = 4'b0100,
    E_SUM  = 4'b1000
  } emit_state_t;

  localparam logic [AW-1:0] DEVICE_BASE = AW'(USER_MAX);
  localparam logic [AW-1:0] EXT_BASE    = AW'(USER_MAX + DEVICE_MAX);

  emit_state_t      state, state_next;
  dtp_job_t         job;
  logic [1:0]       seg, seg_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] seg_cnt;
  logic [AW-1:0]    seg_base;
  logic             free;
  logic             load_byte;
  logic             load_sum;

  assign idle = (state == E_IDLE);
  assign free = !result.valid || result.ready;

  // Count and base address of the segment being read out.
  always_comb begin
    case (seg)
      TAG_USER: begin
        seg_cnt  = job.ucnt;
        seg_base = '0;
      end
      TAG_DEVICE: begin
        seg_cnt  = job.dcnt;
        seg_base = DEVICE_BASE;
      end
      default: begin
        seg_cnt  = job.ecnt;
        seg_base = EXT_BASE;
      end
    endcase
  end

  assign rd_addr = seg_base + AW'(idx);

  // Readout sequencer: read one byte, place it in the output register, repeat.
  always_comb begin
    state_next = state;
    seg_next   = seg;
    idx_next   = idx;
    rd_en      = 1'b0;
    load_byte  = 1'b0;
    load_sum   = 1'b0;
    case (state)
      E_IDLE: begin
        if (start) begin
          seg_next   = TAG_USER;
          idx_next   = '0;
          state_next = job_in.ok ? E_NEXT : E_SUM;
        end
      end
      E_NEXT: begin
        if (idx < seg_cnt) begin
          rd_en      = 1'b1;
          state_next = E_LOAD;
        end else if (seg == TAG_EXT) begin
          state_next = E_SUM;
        end else begin
          seg_next = seg + 2'd1;
          idx_next = '0;
        end
      end
      E_LOAD: begin
        if (free) begin
          load_byte  = 1'b1;
          idx_next   = idx + 5'd1;
          state_next = E_NEXT;
        end
      end
      E_SUM: begin
        if (free) begin
          load_sum   = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  // Sequencer and job registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
    seg <= seg_next;
    idx <= idx_next;
    if (idle && start) begin
      job <= job_in;
    end
  end

  // Output register; it holds its beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_byte || load_sum) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (load_byte) begin
      result.segment_tag   <= seg;
      result.segment_byte  <= rd_data;
      result.parse_ok      <= 1'b0;
      result.message_kind  <= KIND_UNKNOWN;
      result.user_length   <= '0;
      result.device_length <= '0;
      result.ext_length    <= '0;
      result.last_of_run   <= 1'b0;
    end else if (load_sum) begin
      result.segment_tag   <= TAG_SUMMARY;
      result.segment_byte  <= '0;
      result.parse_ok      <= job.ok;
      result.message_kind  <= job.kind;
      result.user_length   <= job.ucnt[3:0];
      result.device_length <= job.dcnt;
      result.ext_length    <= job.ecnt[3:0];
      result.last_of_run   <= 1'b1;
    end
  end

`ifndef SYNTH
  a_start_runs : assert property (@(posedge clk) disable iff (rst)
    (idle && start) |=> !idle)
    else $error("end of topic did not launch a readout run");

  a_load_after_read : assert property (@(posedge clk) disable iff (rst)
    (state == E_LOAD && $past(state) != E_LOAD) |-> $past(rd_en))
    else $error("byte load without a preceding memory read");

  a_byte_in_range : assert property (@(posedge clk) disable iff (rst)
    load_byte |-> (idx < seg_cnt))
    else $error("byte emitted beyond its segment length");

  a_failed_summary : assert property (@(posedge clk) disable iff (rst)
    (load_sum && !job.ok) |-> (job.kind == KIND_UNKNOWN && job.ucnt == '0 &&
                               job.dcnt == '0 && job.ecnt == '0))
    else $error("failed summary carries a kind or lengths");
`endif

endmodule

// ===== design/device_topic_parser_top.sv =====
// Device topic parser.
//
// Topic characters arrive on the topic channel, one beat per character, with
// end_of_topic set on the last one. The parser checks the fixed head, stores
// the user, device and extension type segments in a single memory and tracks
// the suffix candidates in flip-flops. Characters are taken back to back.
//
// On the last character the readout sequencer takes over and the topic channel
// stalls until it is done. It emits the stored bytes on the result channel,
// user first, then device, then extension type, and closes the run with a
// summary beat that has last_of_run set. Each byte is a memory read followed
// by an output register load, each segment boundary takes a sequencer step
// of its own, and the summary beat comes last. A failed topic gives the
// summary alone.
//
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset clears the parse state and the sequencer; the memory
// needs no clearing because only bytes of the current topic are read back.
// The two registers sit on the APB port at byte addresses 0 and 4.
module device_topic_parser_top
  import dtp_pkg::*;
#(
  parameter int USER_MAX   = 16,
  parameter int DEVICE_MAX = 24,
  parameter int EXT_MAX    = 16
) (
  input  logic        clk,
  input  logic        rst,
  dtp_in_if.sink      topic,
  dtp_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = USER_MAX + DEVICE_MAX + EXT_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          ext_capture;
  logic [4:0]    ext_capacity;
  logic          accept;
  logic          idle;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          start;
  dtp_job_t      job;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_capture  <= 1'b1;
      ext_capacity <= 5'd16;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_EXT_CAPTURE:  ext_capture  <= pwdata[0];
        REG_EXT_CAPACITY: ext_capacity <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EXT_CAPTURE:  prdata = {31'd0, ext_capture};
      REG_EXT_CAPACITY: prdata = {27'd0, ext_capacity};
      default:          prdata = '0;
    endcase
  end

  // Characters are taken whenever no readout run is in progress.
  assign topic.ready = idle;
  assign accept      = topic.valid && topic.ready;

  dtp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dtp_parse #(
    .USER_MAX   (USER_MAX),
    .DEVICE_MAX (DEVICE_MAX),
    .EXT_MAX    (EXT_MAX),
    .AW         (AW)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .topic_char   (topic.topic_char),
    .end_of_topic (topic.end_of_topic),
    .ext_capture  (ext_capture),
    .ext_capacity (ext_capacity),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .start        (start),
    .job          (job)
  );

  dtp_emit #(
    .USER_MAX   (USER_MAX),
    .DEVICE_MAX (DEVICE_MAX),
    .AW         (AW)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .job_in  (job),
    .idle    (idle),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .result  (result)
  );

endmodule
